// ===== hw/rtl/s2d_pkg.sv =====
// Shared constants, types and state codes for the signed integer to decimal text unit.
package s2d_pkg;

  // Two's complement width of the printed value.
  localparam int VALUE_WIDTH = 32;

  // Width of the input field as it stands on the port.
  localparam int IN_W = 32;

  // Bits that carry the magnitude and whether a sign bit exists at all.
  localparam int MAG_W = (VALUE_WIDTH < IN_W) ? VALUE_WIDTH : IN_W;
  localparam bit HAS_SIGN = (VALUE_WIDTH <= IN_W);

  // Decimal digit storage.
  localparam int DIGIT_DEPTH = 10;
  localparam int DIGIT_W = 4;
  localparam int DIGIT_IDX_W = $clog2(DIGIT_DEPTH);
  localparam int CNT_W = $clog2(DIGIT_DEPTH + 1);
  localparam int BIT_CNT_W = $clog2(MAG_W);

  // Add-3 correction used by the shift-and-add conversion.
  localparam logic [DIGIT_W-1:0] ADJ_THRESH = 4'd5;
  localparam logic [DIGIT_W-1:0] ADJ_ADD = 4'd3;

  // ASCII codes.
  localparam logic [7:0] CHAR_ZERO = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  // Operation applied to all digit cells together.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_CONVERT,
    CELL_SHIFT
  } cell_op_t;

  // Control from the sequencer to the digit chain.
  typedef struct packed {
    cell_op_t               op;
    logic                   serial_in;
    logic [DIGIT_IDX_W-1:0] tap;
  } chain_ctrl_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_FINISH,
    ST_SIGN,
    ST_DIGITS
  } state_t;

endpackage

// ===== hw/rtl/signed_int_to_decimal_ascii_unit.sv =====
// Top level: prints a signed integer as decimal ASCII text, one character per item.
//
//   Channel | Direction | Payload                    | Handshake
//   --------+-----------+----------------------------+----------------------
//   in_     | input     | in_value[31:0] signed      | in_valid / in_stall
//   out_    | output    | out_character[7:0], out_last | out_valid / out_stall
//
// Each number is loaded, converted in MAG_W shift-and-add-3 steps through the digit
// cell row (32 at the default width) and its digits counted, then printed as up to
// eleven characters while the output side takes them.
// Reset clears the sequencer; the digit cells hold no reset value.
// in_stall is high from acceptance until the last character is taken.
// A stalled character holds, since the digit cells shift only when it leaves.
module signed_int_to_decimal_ascii_unit import s2d_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [IN_W-1:0] in_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_character,
  output logic                   out_last
);

  state_t                 state_r, state_nxt;
  logic [MAG_W-1:0]       mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [DIGIT_IDX_W-1:0] tap_r, tap_nxt;
  logic [CNT_W-1:0]       rem_r, rem_nxt;

  logic [MAG_W-1:0]       in_bits;
  logic                   in_neg;
  logic                   out_take;
  chain_ctrl_t            ctrl;
  logic [DIGIT_W-1:0]     tap_digit;
  logic [CNT_W-1:0]       digit_count;

  // Sign and bits of the incoming value, and the output handshake.
  assign in_bits = in_value[MAG_W-1:0];
  assign in_neg = HAS_SIGN && in_bits[MAG_W-1];
  assign out_take = out_valid && !out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CONVERT;
      end
      ST_CONVERT: begin
        if (bit_cnt_r == '0) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        state_nxt = neg_r ? ST_SIGN : ST_DIGITS;
      end
      ST_SIGN: begin
        if (!out_stall) state_nxt = ST_DIGITS;
      end
      ST_DIGITS: begin
        if (!out_stall && rem_r == CNT_W'(1)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath registers of the sequencer.
  always_comb begin
    mag_nxt = mag_r;
    neg_nxt = neg_r;
    bit_cnt_nxt = bit_cnt_r;
    tap_nxt = tap_r;
    rem_nxt = rem_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mag_nxt = in_neg ? (MAG_W'(0) - in_bits) : in_bits;
          neg_nxt = in_neg;
          bit_cnt_nxt = BIT_CNT_W'(MAG_W - 1);
        end
      end
      ST_CONVERT: begin
        mag_nxt = {mag_r[MAG_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - BIT_CNT_W'(1);
      end
      ST_FINISH: begin
        tap_nxt = DIGIT_IDX_W'(digit_count - CNT_W'(1));
        rem_nxt = digit_count;
      end
      ST_DIGITS: begin
        if (!out_stall) rem_nxt = rem_r - CNT_W'(1);
      end
      default: ;
    endcase
  end

  // Outputs and cell control.
  always_comb begin
    in_stall = (state_r != ST_IDLE);
    out_valid = (state_r == ST_SIGN) || (state_r == ST_DIGITS);
    out_last = (state_r == ST_DIGITS) && (rem_r == CNT_W'(1));
    out_character = (state_r == ST_SIGN) ? CHAR_MINUS
                                         : (CHAR_ZERO + {4'b0000, tap_digit});
    ctrl.serial_in = mag_r[MAG_W-1];
    ctrl.tap = tap_r;
    case (state_r)
      ST_IDLE:    ctrl.op = in_valid ? CELL_CLEAR : CELL_HOLD;
      ST_CONVERT: ctrl.op = CELL_CONVERT;
      ST_DIGITS:  ctrl.op = out_take ? CELL_SHIFT : CELL_HOLD;
      default:    ctrl.op = CELL_HOLD;
    endcase
  end

  // Control state takes reset; payload registers do not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    tap_r <= tap_nxt;
    rem_r <= rem_nxt;
  end

  s2d_digit_chain u_chain (
    .clk         (clk),
    .ctrl        (ctrl),
    .tap_digit   (tap_digit),
    .digit_count (digit_count)
  );

endmodule

// ===== hw/rtl/s2d_digit_cell.sv =====
// One decimal digit cell of the shift-and-add-3 conversion chain.
module s2d_digit_cell import s2d_pkg::*; (
  input  logic               clk,
  input  cell_op_t           op,
  input  logic               carry_in,
  input  logic [DIGIT_W-1:0] shift_in,
  output logic [DIGIT_W-1:0] digit,
  output logic               carry_out
);

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;
  logic [DIGIT_W-1:0] adj;

  // Correct the digit before it doubles so it stays in decimal range.
  always_comb begin
    adj = (digit_r >= ADJ_THRESH) ? (digit_r + ADJ_ADD) : digit_r;
  end

  // Next digit: clear, convert step, shift from the lower cell, or hold.
  always_comb begin
    case (op)
      CELL_CLEAR:   digit_nxt = '0;
      CELL_CONVERT: digit_nxt = {adj[DIGIT_W-2:0], carry_in};
      CELL_SHIFT:   digit_nxt = shift_in;
      default:      digit_nxt = digit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit = digit_r;
  assign carry_out = adj[DIGIT_W-1];

endmodule

// ===== hw/rtl/s2d_digit_chain.sv =====
// Row of digit cells with the digit count encoder and the output tap.
module s2d_digit_chain import s2d_pkg::*; (
  input  logic               clk,
  input  chain_ctrl_t        ctrl,
  output logic [DIGIT_W-1:0] tap_digit,
  output logic [CNT_W-1:0]   digit_count
);

  logic [DIGIT_W-1:0] digits [DIGIT_DEPTH];
  logic               carry  [DIGIT_DEPTH];

  // Cell 0 takes the serial magnitude bit; each cell feeds its upper neighbor.
  // The top cell's carry goes nowhere, since ten digits hold any input.
  for (genvar i = 0; i < DIGIT_DEPTH; i++) begin : g_cell
    logic               cin;
    logic [DIGIT_W-1:0] sin;

    if (i == 0) begin : g_first
      assign cin = ctrl.serial_in;
      assign sin = '0;
    end else begin : g_rest
      assign cin = carry[i-1];
      assign sin = digits[i-1];
    end

    s2d_digit_cell u_cell (
      .clk       (clk),
      .op        (ctrl.op),
      .carry_in  (cin),
      .shift_in  (sin),
      .digit     (digits[i]),
      .carry_out (carry[i])
    );
  end

  // Number of significant digits; zero still prints one digit.
  always_comb begin
    digit_count = CNT_W'(1);
    for (int i = 1; i < DIGIT_DEPTH; i++) begin
      if (digits[i] != '0) begin
        digit_count = CNT_W'(i + 1);
      end
    end
  end

  // The most significant remaining digit always sits at the tap cell.
  assign tap_digit = digits[ctrl.tap];

endmodule
